>>> hw/rtl/b64e_pkg.sv
// Shared types, register indexes and the Base64 symbol map for the encoder.
package b64e_pkg;

    localparam logic [7:0] CHAR_PAD = 8'h3D;
    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_LF  = 8'h0A;

    localparam logic [6:0] LINE_MAX_CHARS = 7'd76;

    localparam int unsigned GROUP_CHARS = 6;

    // configuration register indexes
    localparam logic REG_WRAP_ENABLE = 1'b0;
    localparam logic REG_LINE_LENGTH = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_end;
    } in_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       run_last;
    } out_t;

    // one encoded group: characters in emit order (index 0 first)
    typedef struct packed {
        logic [GROUP_CHARS-1:0][7:0] chars;
        logic [2:0]                  count;
        logic [6:0]                  column_next;
    } grp_t;

    function automatic logic [7:0] sym(input logic [5:0] idx);
        logic [7:0] ch;
        ch = 8'h00;
        case (idx) inside
            [6'd0:6'd25]:  ch = 8'h41 + {2'b00, idx};
            [6'd26:6'd51]: ch = 8'h61 + {2'b00, idx} - 8'd26;
            [6'd52:6'd61]: ch = 8'h30 + {2'b00, idx} - 8'd52;
            6'd62:         ch = 8'h2B;
            6'd63:         ch = 8'h2F;
            default:       ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

>>> hw/rtl/base64_encode_line_wrap_top.sv
// Top level of the Base64 encoder with optional CR LF line wrapping.
//
//  channel | ports                          | carries
//  --------+--------------------------------+----------------------------------
//  input   | s_valid s_ready s_payload      | one raw byte + end-of-stream flag
//  result  | m_valid m_ready m_payload      | one character + last-of-request
//  config  | cfg_wr_en cfg_addr cfg_wdata   | wrap_enable (0), line_length (1)
//
// A request is registered in the input stage on acceptance. A byte that only
// fills the group is then parked in the two-byte pending store (no result); the
// request that completes a group is encoded into the character shift register,
// whose head drives m_payload, once that register is free to load it.
// One character leaves per cycle while m_ready is high; a group is four
// characters, or six with CR LF, also for a lone byte flushed by the end flag.
// Bytes that only fill the pending store are taken every cycle even while
// characters are draining.
// Reset (aresetn low, synchronous) empties the input stage, the pending store
// count and the shift register, zeroes the column, clears wrap_enable and
// sets line_length to 76. A stalled m_ready holds the head character; once the
// held request completes a group, the input stage stays full and s_ready drops.
module base64_encode_line_wrap_top import b64e_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       s_valid,
    output logic       s_ready,
    input  in_t        s_payload,

    output logic       m_valid,
    input  logic       m_ready,
    output out_t       m_payload,

    input  logic       cfg_wr_en,
    input  logic       cfg_addr,
    input  logic [6:0] cfg_wdata
);

    // configuration
    logic       wrap_en_reg;
    logic [6:0] line_len_reg;

    // input stage
    logic       in_valid_reg;
    in_t        in_data_reg;

    // encoder state
    logic [7:0] pend_reg [2];
    logic [1:0] pend_cnt_reg;
    logic [6:0] column_reg;

    // character shift register, head at index 0
    logic [GROUP_CHARS-1:0][7:0] chars_reg;
    logic [2:0]                  left_reg;

    logic       fire;       // held request completes a group
    logic       grp_free;   // shift register can load a group this edge
    logic       consume;    // held request leaves the input stage
    logic       pop;
    logic [7:0] g0, g1, g2;
    logic [1:0] n_bytes;
    grp_t       grp;

    // group assembly from pending bytes plus the held byte
    always_comb begin
        g0 = in_data_reg.data_byte;
        g1 = 8'h00;
        g2 = 8'h00;
        case (pend_cnt_reg)
            2'd1: begin
                g0 = pend_reg[0];
                g1 = in_data_reg.data_byte;
            end
            2'd2: begin
                g0 = pend_reg[0];
                g1 = pend_reg[1];
                g2 = in_data_reg.data_byte;
            end
            default: ;
        endcase
        n_bytes = (pend_cnt_reg >= 2'd2) ? 2'd3 : pend_cnt_reg + 2'd1;
    end

    b64e_group u_group (
        .byte0       (g0),
        .byte1       (g1),
        .byte2       (g2),
        .n_bytes     (n_bytes),
        .column      (column_reg),
        .wrap_enable (wrap_en_reg),
        .line_length (line_len_reg),
        .grp         (grp)
    );

    assign pop      = m_valid && m_ready;
    assign fire     = in_valid_reg && (in_data_reg.stream_end || pend_cnt_reg == 2'd2);
    assign grp_free = (left_reg == 3'd0) || (m_ready && left_reg == 3'd1);
    assign consume  = in_valid_reg && (!fire || grp_free);
    assign s_ready  = !in_valid_reg || consume;

    assign m_valid             = (left_reg != 3'd0);
    assign m_payload.out_char  = chars_reg[0];
    assign m_payload.run_last  = (left_reg == 3'd1);

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wrap_en_reg  <= 1'b0;
            line_len_reg <= LINE_MAX_CHARS;
            in_valid_reg <= 1'b0;
            pend_cnt_reg <= 2'd0;
            column_reg   <= 7'd0;
            left_reg     <= 3'd0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_WRAP_ENABLE: wrap_en_reg <= cfg_wdata[0];
                    REG_LINE_LENGTH: line_len_reg <= (cfg_wdata > LINE_MAX_CHARS) ?
                                                     LINE_MAX_CHARS : cfg_wdata;
                    default: ;
                endcase
            end

            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (consume) begin
                in_valid_reg <= 1'b0;
            end

            if (consume) begin
                if (fire) begin
                    pend_cnt_reg <= 2'd0;
                    column_reg   <= grp.column_next;
                end else begin
                    pend_cnt_reg <= pend_cnt_reg + 2'd1;
                end
            end

            if (consume && fire) begin
                left_reg <= grp.count;
            end else if (pop) begin
                left_reg <= left_reg - 3'd1;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_payload;
        end
        if (consume && !fire) begin
            pend_reg[pend_cnt_reg[0]] <= in_data_reg.data_byte;
        end
        if (consume && fire) begin
            chars_reg <= grp.chars;
        end else if (pop) begin
            chars_reg <= {8'h00, chars_reg[GROUP_CHARS-1:1]};
        end
    end

endmodule

>>> hw/rtl/b64e_group.sv
// Turns one group of one to three bytes into four symbols plus an optional CR LF.
module b64e_group import b64e_pkg::*; (
    input  logic [7:0] byte0,
    input  logic [7:0] byte1,
    input  logic [7:0] byte2,
    input  logic [1:0] n_bytes,      // 1..3
    input  logic [6:0] column,
    input  logic       wrap_enable,
    input  logic [6:0] line_length,
    output grp_t       grp
);

    logic [6:0] col4;
    logic       brk;

    assign col4 = column + 7'd4;
    assign brk  = wrap_enable && (({1'b0, col4} + 8'd6) >= {1'b0, line_length});

    always_comb begin
        grp.chars[0] = sym(byte0[7:2]);
        grp.chars[1] = sym({byte0[1:0], byte1[7:4]});
        grp.chars[2] = (n_bytes >= 2'd2) ? sym({byte1[3:0], byte2[7:6]}) : CHAR_PAD;
        grp.chars[3] = (n_bytes == 2'd3) ? sym(byte2[5:0]) : CHAR_PAD;
        grp.chars[4] = brk ? CHAR_CR : 8'h00;
        grp.chars[5] = brk ? CHAR_LF : 8'h00;
        grp.count       = brk ? 3'd6 : 3'd4;
        grp.column_next = brk ? 7'd0 : col4;
    end

endmodule

>>> hw/rtl/b64e_checker.sv
// Port-level checks on the encoder top level, bound in below.
module b64e_checker import b64e_pkg::*; (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input in_t  s_payload,
    input logic m_valid,
    input logic m_ready,
    input out_t m_payload
);

    // waiting request holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_payload))
        else $error("request changed while waiting");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("result changed while stalled");

    // a CR is always followed at once by an LF that closes the request
    a_crlf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_payload.out_char == CHAR_CR && !m_payload.run_last |=>
        m_valid && m_payload.out_char == CHAR_LF && m_payload.run_last)
        else $error("CR not followed by closing LF");

    // reset empties both sides
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("not empty after reset");

    // a request never ends on a CR
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.run_last |-> m_payload.out_char != CHAR_CR)
        else $error("request ends on CR");

endmodule

bind base64_encode_line_wrap_top b64e_checker u_b64e_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_payload (s_payload),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_payload (m_payload)
);
